@@ src/hsfc_pkg.sv @@
// Package: sizes, function codes, register indexes and flag masks of the floppy controller.
`timescale 1ns / 1ps
package hsfc_pkg;

  localparam int DRIVES       = 4;
  localparam int TRACKS       = 77;
  localparam int SECTORS      = 32;
  localparam int SECTOR_BYTES = 137;
  localparam int IMAGE_BYTES  = DRIVES * TRACKS * SECTORS * SECTOR_BYTES;

  localparam int SEL_W   = $clog2(DRIVES + 1);
  localparam int DIDX_W  = (DRIVES > 1) ? $clog2(DRIVES) : 1;
  localparam int ROW_W   = $clog2(DRIVES * TRACKS * SECTORS);
  localparam int ADDR_W  = $clog2(IMAGE_BYTES);
  localparam int BUF_AW  = $clog2(SECTOR_BYTES);
  localparam int CNT_W   = $clog2(SECTOR_BYTES + 1);

  localparam int MASK_W  = 4;
  localparam int TC_W    = 7;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 7;

  // function codes
  localparam logic [2:0] F_STATUS  = 3'd0;
  localparam logic [2:0] F_SELECT  = 3'd1;
  localparam logic [2:0] F_SECTOR  = 3'd2;
  localparam logic [2:0] F_CONTROL = 3'd3;
  localparam logic [2:0] F_DATA_RD = 3'd4;
  localparam logic [2:0] F_DATA_WR = 3'd5;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] REG_ATTACHED   = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WRITE_LOCK = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TRACKS     = 2'd2;

  localparam logic [7:0] NO_POS         = 8'hff;
  localparam logic [7:0] FLAGS_SEL_TRK0 = 8'h5a;
  localparam logic [7:0] FLAGS_SEL      = 8'h1a;
  localparam logic [7:0] SECT_MASK      = 8'h3e;
  localparam logic [7:0] SECT_TRUE      = 8'hc0;
  localparam logic [7:0] CLR_TRK0       = 8'hbf;
  localparam logic [7:0] SET_TRK0       = 8'h40;
  localparam logic [7:0] SET_HEAD       = 8'h84;
  localparam logic [7:0] CLR_HEAD       = 8'h7b;
  localparam logic [7:0] CLR_WREN       = 8'hfe;
  localparam logic [7:0] SET_WREN       = 8'h01;
  localparam logic [7:0] FLAG_HEAD      = 8'h04;

endpackage

@@ src/hsfc_if.sv @@
// Interfaces: access request channel and read value channel.
`timescale 1ns / 1ps
interface hsfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data;
  modport source (output valid, output func, output data, input ready);
  modport sink (input valid, input func, input data, output ready);
endinterface

interface hsfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_value;
  modport source (output valid, output read_value, input ready);
  modport sink (input valid, input read_value, output ready);
endinterface

@@ src/hsfc_ram.sv @@
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module hsfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/hard_sector_floppy_controller_top.sv @@
// Top level: hard-sectored floppy controller with sector buffer and disk image store.
//
//  channel | dir | payload            | handshake
//  in_ch   | in  | func[3], data[8]   | valid/ready
//  out_ch  | out | read_value[8]      | valid/ready
//  cfg     | in  | cfg_index, cfg_data| cfg_wr_en, no stall
//
// An access passes through accept, decode, execute and result steps; a data
// read adds a read-wait step. A sector load adds the base-address states S_BASE1
// and S_BASE2 and a copy pass; a commit also adds the closing state S_CEND.
// After reset the image and buffer are cleared, one byte a cycle, over all
// IMAGE_BYTES (1350272) bytes of the image; no access is taken meanwhile.
// One access at a time; a result waits in the output register while the next
// access is accepted, and the sequencer holds in its result state until it drains.
`timescale 1ns / 1ps
module hard_sector_floppy_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  hsfc_in_if.sink                       in_ch,
  hsfc_out_if.source                    out_ch,
  input  logic                          cfg_wr_en,
  input  logic [hsfc_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [hsfc_pkg::CDATA_W-1:0]  cfg_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PRE   = 4'd2;
  localparam logic [3:0] S_BASE1 = 4'd3;
  localparam logic [3:0] S_BASE2 = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_CEND  = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_RDWT  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_COMMIT = 1'b1;

  logic [3:0] state;
  logic       mode;

  logic [hsfc_pkg::MASK_W-1:0] attached_mask;
  logic [hsfc_pkg::MASK_W-1:0] write_lock_mask;
  logic [hsfc_pkg::TC_W-1:0]   track_count;

  logic [hsfc_pkg::SEL_W-1:0] sel;
  logic [7:0] head_track      [hsfc_pkg::DRIVES];
  logic [7:0] sector_position [hsfc_pkg::DRIVES];
  logic [7:0] byte_position   [hsfc_pkg::DRIVES];
  logic [7:0] status_flags    [hsfc_pkg::DRIVES];
  logic       buffer_dirty;

  logic [2:0] fn;
  logic [7:0] dt;
  logic [7:0] res;
  logic       out_valid;
  logic [7:0] read_value;

  logic [hsfc_pkg::ADDR_W-1:0] clr_cnt;
  logic [hsfc_pkg::ROW_W-1:0]  row;
  logic [hsfc_pkg::ADDR_W-1:0] base;
  logic                        copy_ok;
  logic [hsfc_pkg::CNT_W-1:0]  cnt;
  logic                        p_valid;
  logic [hsfc_pkg::CNT_W-1:0]  p_idx;

  // memory ports
  logic                        img_we;
  logic [hsfc_pkg::ADDR_W-1:0] img_waddr;
  logic [7:0]                  img_wdata;
  logic [hsfc_pkg::ADDR_W-1:0] img_raddr;
  logic [7:0]                  img_rdata;
  logic                        buf_we;
  logic [hsfc_pkg::BUF_AW-1:0] buf_waddr;
  logic [7:0]                  buf_wdata;
  logic [hsfc_pkg::BUF_AW-1:0] buf_raddr;
  logic [7:0]                  buf_rdata;

  // selected-drive view
  logic [hsfc_pkg::DIDX_W-1:0] di;
  logic                        sel_ok;
  logic [7:0] cur_ht, cur_sp, cur_bp, cur_fl;
  logic       need_commit;
  logic       issue;
  logic [7:0] copy_val;

  // control write results
  logic [7:0] lim;
  logic [6:0] n_tr;
  logic [8:0] t_inc;
  logic [7:0] c_ht, c_sp, c_bp, c_fl;
  // sector read
  logic [8:0] s_inc;
  logic [7:0] s_new;
  logic [7:0] exec_res;
  // select
  logic [3:0]                  dsel;
  logic [hsfc_pkg::DIDX_W-1:0] dsel_i;
  logic                        dsel_ok;

  assign di     = sel[hsfc_pkg::DIDX_W-1:0];
  assign sel_ok = (sel < hsfc_pkg::SEL_W'(hsfc_pkg::DRIVES));
  assign cur_ht = head_track[di];
  assign cur_sp = sector_position[di];
  assign cur_bp = byte_position[di];
  assign cur_fl = status_flags[di];

  assign need_commit = (((fn == hsfc_pkg::F_SELECT) || (fn == hsfc_pkg::F_SECTOR) ||
                         (fn == hsfc_pkg::F_CONTROL)) && buffer_dirty) ||
                       ((fn == hsfc_pkg::F_DATA_WR) && sel_ok &&
                        (cur_bp >= 8'(hsfc_pkg::SECTOR_BYTES)));

  assign issue = (cnt < hsfc_pkg::CNT_W'(hsfc_pkg::SECTOR_BYTES));

  always_comb begin
    if (mode == MODE_COMMIT) begin
      copy_val = (8'(p_idx) >= cur_bp) ? 8'd0 : buf_rdata;
    end else begin
      copy_val = copy_ok ? img_rdata : 8'd0;
    end
  end

  // memory port steering
  always_comb begin
    img_we    = 1'b0;
    img_waddr = base + hsfc_pkg::ADDR_W'(p_idx);
    img_wdata = copy_val;
    img_raddr = base + hsfc_pkg::ADDR_W'(cnt);
    buf_we    = 1'b0;
    buf_waddr = p_idx[hsfc_pkg::BUF_AW-1:0];
    buf_wdata = copy_val;
    buf_raddr = (state == S_COPY) ? cnt[hsfc_pkg::BUF_AW-1:0]
                                  : cur_bp[hsfc_pkg::BUF_AW-1:0];
    case (state)
      S_CLEAR: begin
        img_we    = 1'b1;
        img_waddr = clr_cnt;
        img_wdata = 8'd0;
        buf_we    = (clr_cnt < hsfc_pkg::ADDR_W'(hsfc_pkg::SECTOR_BYTES));
        buf_waddr = clr_cnt[hsfc_pkg::BUF_AW-1:0];
        buf_wdata = 8'd0;
      end
      S_COPY: begin
        buf_we = p_valid;
        img_we = p_valid && (mode == MODE_COMMIT) && copy_ok;
      end
      S_EXEC: begin
        if ((fn == hsfc_pkg::F_DATA_WR) && sel_ok &&
            (cur_bp < 8'(hsfc_pkg::SECTOR_BYTES))) begin
          buf_we    = 1'b1;
          buf_waddr = cur_bp[hsfc_pkg::BUF_AW-1:0];
          buf_wdata = dt;
        end
      end
      default: begin
      end
    endcase
  end

  // control write: apply bits in order on the selected drive
  always_comb begin
    if (track_count == 7'd0) begin
      n_tr = 7'd1;
    end else if (track_count > 7'(hsfc_pkg::TRACKS)) begin
      n_tr = 7'(hsfc_pkg::TRACKS);
    end else begin
      n_tr = track_count;
    end
    lim   = 8'(n_tr) - 8'd1;
    c_ht  = cur_ht;
    c_sp  = cur_sp;
    c_bp  = cur_bp;
    c_fl  = cur_fl;
    t_inc = {1'b0, cur_ht} + 9'd1;
    if (dt[0]) begin
      c_ht = (t_inc > {1'b0, lim}) ? lim : t_inc[7:0];
      c_fl = c_fl & hsfc_pkg::CLR_TRK0;
      c_sp = hsfc_pkg::NO_POS;
      c_bp = hsfc_pkg::NO_POS;
    end
    if (dt[1]) begin
      if (c_ht != 8'd0) begin
        c_ht = c_ht - 8'd1;
      end
      if (c_ht == 8'd0) begin
        c_fl = c_fl | hsfc_pkg::SET_TRK0;
      end
      c_sp = hsfc_pkg::NO_POS;
      c_bp = hsfc_pkg::NO_POS;
    end
    if (dt[2]) begin
      c_fl = c_fl | hsfc_pkg::SET_HEAD;
    end
    if (dt[3]) begin
      c_fl = c_fl & hsfc_pkg::CLR_HEAD;
      c_sp = hsfc_pkg::NO_POS;
      c_bp = hsfc_pkg::NO_POS;
    end
    if (dt[7]) begin
      c_bp = 8'd0;
      c_fl = c_fl | hsfc_pkg::SET_WREN;
    end
  end

  always_comb begin
    s_inc = {1'b0, cur_sp} + 9'd1;
    s_new = (s_inc >= 9'(hsfc_pkg::SECTORS)) ? 8'd0 : s_inc[7:0];
  end

  // read value of accesses that finish in the execute step
  always_comb begin
    exec_res = 8'd0;
    if (fn == hsfc_pkg::F_STATUS) begin
      exec_res = sel_ok ? ~cur_fl : 8'hff;
    end else if ((fn == hsfc_pkg::F_SECTOR) && sel_ok &&
                 ((cur_fl & hsfc_pkg::FLAG_HEAD) != 8'd0)) begin
      exec_res = ({s_new[6:0], 1'b0} & hsfc_pkg::SECT_MASK) | hsfc_pkg::SECT_TRUE;
    end
  end

  assign dsel    = dt[3:0];
  assign dsel_i  = dsel[hsfc_pkg::DIDX_W-1:0];
  assign dsel_ok = (dsel < 4'(hsfc_pkg::DRIVES)) && attached_mask[dsel_i];

  assign in_ch.ready       = (state == S_IDLE);
  assign out_ch.valid      = out_valid;
  assign out_ch.read_value = read_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_CLEAR;
      mode            <= MODE_LOAD;
      clr_cnt         <= '0;
      attached_mask   <= '0;
      write_lock_mask <= '0;
      track_count     <= 7'(hsfc_pkg::TRACKS);
      sel             <= hsfc_pkg::SEL_W'(hsfc_pkg::DRIVES);
      buffer_dirty    <= 1'b0;
      out_valid       <= 1'b0;
      cnt             <= '0;
      p_valid         <= 1'b0;
      for (int i = 0; i < hsfc_pkg::DRIVES; i++) begin
        head_track[i]      <= 8'd0;
        sector_position[i] <= 8'd0;
        byte_position[i]   <= 8'd0;
        status_flags[i]    <= 8'd0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hsfc_pkg::REG_ATTACHED:   attached_mask   <= cfg_data[hsfc_pkg::MASK_W-1:0];
          hsfc_pkg::REG_WRITE_LOCK: write_lock_mask <= cfg_data[hsfc_pkg::MASK_W-1:0];
          hsfc_pkg::REG_TRACKS:     track_count     <= cfg_data[hsfc_pkg::TC_W-1:0];
          default: begin
          end
        endcase
      end
      // drop the beat once taken, unless a new one is loaded below
      if (out_valid && out_ch.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == hsfc_pkg::ADDR_W'(hsfc_pkg::IMAGE_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            fn    <= in_ch.func;
            dt    <= in_ch.data;
            state <= S_PRE;
          end
        end
        S_PRE: begin
          if (need_commit) begin
            if (sel_ok) begin
              mode  <= MODE_COMMIT;
              state <= S_BASE1;
            end else begin
              buffer_dirty <= 1'b0;
              state        <= S_EXEC;
            end
          end else if ((fn == hsfc_pkg::F_DATA_RD) && sel_ok &&
                       (cur_bp >= 8'(hsfc_pkg::SECTOR_BYTES))) begin
            mode  <= MODE_LOAD;
            state <= S_BASE1;
          end else begin
            state <= S_EXEC;
          end
        end
        S_BASE1: begin
          row <= hsfc_pkg::ROW_W'((hsfc_pkg::ROW_W'(di) * hsfc_pkg::ROW_W'(hsfc_pkg::TRACKS)
                 + hsfc_pkg::ROW_W'(cur_ht)) * hsfc_pkg::ROW_W'(hsfc_pkg::SECTORS)
                 + hsfc_pkg::ROW_W'(cur_sp));
          copy_ok <= (cur_ht < 8'(hsfc_pkg::TRACKS)) && (cur_sp < 8'(hsfc_pkg::SECTORS)) &&
                     ((mode == MODE_LOAD) || !write_lock_mask[di]);
          cnt     <= '0;
          p_valid <= 1'b0;
          state   <= S_BASE2;
        end
        S_BASE2: begin
          base  <= hsfc_pkg::ADDR_W'(row) * hsfc_pkg::ADDR_W'(hsfc_pkg::SECTOR_BYTES);
          state <= S_COPY;
        end
        S_COPY: begin
          // read one byte ahead, write the byte read last cycle
          p_valid <= issue;
          p_idx   <= cnt;
          if (issue) begin
            cnt <= cnt + 1'b1;
          end
          if (!issue && !p_valid) begin
            if (mode == MODE_COMMIT) begin
              state <= S_CEND;
            end else begin
              byte_position[di] <= 8'd0;
              state             <= S_EXEC;
            end
          end
        end
        S_CEND: begin
          status_flags[di]  <= cur_fl & hsfc_pkg::CLR_WREN;
          byte_position[di] <= hsfc_pkg::NO_POS;
          buffer_dirty      <= 1'b0;
          state             <= S_EXEC;
        end
        S_EXEC: begin
          res   <= exec_res;
          state <= ((fn == hsfc_pkg::F_DATA_RD) && sel_ok) ? S_RDWT : S_DONE;
          if (fn == hsfc_pkg::F_SELECT) begin
            if (dsel_ok) begin
              sel                     <= hsfc_pkg::SEL_W'(dsel);
              sector_position[dsel_i] <= hsfc_pkg::NO_POS;
              byte_position[dsel_i]   <= hsfc_pkg::NO_POS;
              status_flags[dsel_i]    <= dt[7] ? 8'd0 :
                                         ((head_track[dsel_i] == 8'd0) ?
                                          hsfc_pkg::FLAGS_SEL_TRK0 : hsfc_pkg::FLAGS_SEL);
            end else begin
              sel <= hsfc_pkg::SEL_W'(hsfc_pkg::DRIVES);
            end
          end else if (sel_ok) begin
            case (fn)
              hsfc_pkg::F_SECTOR: begin
                if ((cur_fl & hsfc_pkg::FLAG_HEAD) != 8'd0) begin
                  sector_position[di] <= s_new;
                  byte_position[di]   <= hsfc_pkg::NO_POS;
                end
              end
              hsfc_pkg::F_CONTROL: begin
                head_track[di]      <= c_ht;
                sector_position[di] <= c_sp;
                byte_position[di]   <= c_bp;
                status_flags[di]    <= c_fl;
              end
              hsfc_pkg::F_DATA_WR: begin
                if (cur_bp < 8'(hsfc_pkg::SECTOR_BYTES)) begin
                  buffer_dirty      <= 1'b1;
                  byte_position[di] <= cur_bp + 8'd1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RDWT: begin
          res               <= buf_rdata;
          byte_position[di] <= cur_bp + 8'd1;
          state             <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid  <= 1'b1;
            read_value <= res;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  hsfc_ram #(
    .WIDTH(8),
    .DEPTH(hsfc_pkg::IMAGE_BYTES)
  ) u_image (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  hsfc_ram #(
    .WIDTH(8),
    .DEPTH(hsfc_pkg::SECTOR_BYTES)
  ) u_buffer (
    .clk   (clk),
    .we    (buf_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ch.ready)
    else $error("access taken during clearing pass");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == S_PRE))
    else $error("sequencer did not start after accept");

  a_dirty_has_drive: assert property (@(posedge clk) disable iff (rst)
    buffer_dirty |-> sel_ok)
    else $error("dirty buffer with no drive selected");

  a_copy_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY) |-> (cnt <= hsfc_pkg::CNT_W'(hsfc_pkg::SECTOR_BYTES)))
    else $error("copy counter past sector end");

endmodule
